[rtl/wfht_pkg.sv]
// Shared types and constants of the wildcard fallback handler table.
// Key field layout, command and status codes, probe result record.
// No dependencies.
package wfht_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam int FAM_W = 8;
	localparam int GEN_W = 8;
	localparam int SPC_W = 16;
	localparam int EVT_W = 16;
	localparam int HDL_W = 16;
	localparam int KEY_W = FAM_W + GEN_W + SPC_W + EVT_W;
	localparam int ENT_W = KEY_W + HDL_W;

	localparam int GEN_LO = FAM_W;
	localparam int SPC_LO = GEN_LO + GEN_W;
	localparam int EVT_LO = SPC_LO + SPC_W;

	localparam logic [KEY_W-1:0] GEN_MASK = {{(KEY_W-GEN_W){1'b0}}, {GEN_W{1'b1}}} << GEN_LO;
	localparam logic [KEY_W-1:0] SPC_MASK = {{(KEY_W-SPC_W){1'b0}}, {SPC_W{1'b1}}} << SPC_LO;
	localparam logic [KEY_W-1:0] EVT_MASK = {{(KEY_W-EVT_W){1'b0}}, {EVT_W{1'b1}}} << EVT_LO;

	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_DEL    = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	localparam logic [1:0] LVL_EXACT   = 2'd0;
	localparam logic [1:0] LVL_SPECIES = 2'd1;
	localparam logic [1:0] LVL_GENUS   = 2'd2;
	localparam logic [1:0] LVL_ALL     = 2'd3;

	typedef struct packed {
		logic             hit;
		logic [1:0]       lvl;
		logic [HDL_W-1:0] hdl;
	} scan_res_t;

endpackage

[rtl/wildcard_fallback_handler_table.sv]
// Top level of the wildcard fallback handler table: command sequencer,
// entry count and result register. Uses wfht_pkg, wfht_ram, wfht_probe.
//
// Use: commands enter on the s_axis channel, one beat per command; each
// command gives exactly one result beat on m_axis. Add stores or overwrites
// a handle, delete removes a key, lookup tries the exact key and then the
// species, genus and all-classifier wildcards in that order.
// Entries are kept packed in RAM rows 0 to count-1; a delete moves the last
// row into the freed one, so a row is valid exactly when it lies below the
// count. Every command scans the occupied rows once through the single RAM
// read port, one row per cycle, comparing all four probe keys in parallel.
// After the scan the sequencer passes S_DRAIN and S_FIN, where the result
// is loaded; an empty table goes straight to S_FIN. The next beat is taken
// in S_IDLE after the result is loaded. The RAM read port sets the rate.
// Reset clears the count, so the table is empty at once with no sweep.
// A stalled receiver holds the result register; the next command is still
// taken and scanned, and waits to write back until the result is taken.
module wildcard_fallback_handler_table import wfht_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// family_id[7:0], genus_id[15:8], species_id[31:16], event_id[47:32],
	// handler_in[63:48]
	input  logic [ENT_W-1:0]      s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// handler_out[15:0], match_level[17:16], zero[23:18]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]            m_axis_tuser
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t           state_q;
	logic [1:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [HDL_W-1:0] hdl_in_q;
	logic [IW-1:0]    idx_q;
	logic [CW-1:0]    count_q;
	logic             rd_vld_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic [ENT_W-1:0] last_q;
	logic             m_valid_q;
	logic [1:0]       st_q;
	logic [HDL_W-1:0] hout_q;
	logic [1:0]       lvl_q;

	logic             accept;
	logic             rd_en;
	logic [ENT_W-1:0] rd_data;
	logic [CW-1:0]    cnt_m1;
	logic [IW-1:0]    last_idx;
	logic             out_free;
	logic             fin;
	logic             exact;
	scan_res_t        res;
	logic [IW-1:0]    exact_idx;

	logic             wr_en;
	logic [IW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic             cnt_inc;
	logic             cnt_dec;
	logic [1:0]       st_d;
	logic [HDL_W-1:0] hout_d;
	logic [1:0]       lvl_d;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign rd_en         = (state_q == S_SCAN);
	assign cnt_m1        = count_q - CW'(1);
	assign last_idx      = cnt_m1[IW-1:0];
	assign out_free      = !m_valid_q || m_axis_tready;
	assign fin           = (state_q == S_FIN) && out_free;
	assign exact         = res.hit && (res.lvl == LVL_EXACT);

	wfht_ram #(
		.W (ENT_W),
		.D (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	wfht_probe #(
		.IW (IW)
	) u_probe (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.rd_vld    (rd_vld_s1),
		.rd_idx    (rd_idx_s1),
		.rd_data   (rd_data),
		.key       (key_q),
		.res       (res),
		.exact_idx (exact_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (count_q == '0) ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == last_idx) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= cnt_m1;
			end
			if (fin) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_axis_tuser;
			key_q    <= s_axis_tdata[KEY_W-1:0];
			hdl_in_q <= s_axis_tdata[ENT_W-1:KEY_W];
			idx_q    <= '0;
		end else if (rd_en) begin
			idx_q <= idx_q + IW'(1);
		end
		if (rd_en) begin
			rd_idx_s1 <= idx_q;
		end
		// the final read of a scan is the last occupied row
		if (rd_vld_s1) begin
			last_q <= rd_data;
		end
		if (fin) begin
			st_q   <= st_d;
			hout_q <= hout_d;
			lvl_q  <= lvl_d;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = exact_idx;
		wr_data = {hdl_in_q, key_q};
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		st_d    = ST_OK;
		hout_d  = '0;
		lvl_d   = LVL_EXACT;
		unique case (cmd_q)
			CMD_ADD: begin
				if (exact) begin
					wr_en = fin;
				end else if (count_q < CW'(ENTRIES)) begin
					wr_en   = fin;
					wr_addr = count_q[IW-1:0];
					cnt_inc = fin;
				end else begin
					st_d = ST_FULL;
				end
			end
			CMD_DEL: begin
				// fill the hole with the last row, then shrink
				if (exact) begin
					wr_en   = fin;
					wr_data = last_q;
					cnt_dec = fin;
				end
			end
			CMD_LOOKUP: begin
				if (res.hit) begin
					hout_d = res.hdl;
					lvl_d  = res.lvl;
				end else begin
					st_d = ST_MISS;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-HDL_W-2){1'b0}}, lvl_q, hout_q};
	assign m_axis_tuser  = st_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count above table size");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !rd_vld_s1)
		else $error("read in flight while taking a new beat");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_FULL) |-> count_q == CW'(ENTRIES))
		else $error("full status reported with free rows");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && cmd_q == CMD_DEL && exact) |=> count_q == $past(cnt_m1))
		else $error("delete hit did not shrink the table");

endmodule

[rtl/wfht_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wfht_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/wfht_probe.sv]
// Probe unit: compares each entry read from the table against the four
// fallback keys and keeps the best hit of the running scan. Uses wfht_pkg.
module wfht_probe import wfht_pkg::*; #(
	parameter int IW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             rd_vld,
	input  logic [IW-1:0]    rd_idx,
	input  logic [ENT_W-1:0] rd_data,
	input  logic [KEY_W-1:0] key,
	output scan_res_t        res,
	output logic [IW-1:0]    exact_idx
);

	logic [KEY_W-1:0] probe [4];
	logic [3:0]       hits;
	logic             new_hit;
	logic [1:0]       new_lvl;
	logic             hit_q;
	logic [1:0]       lvl_q;
	logic [HDL_W-1:0] hdl_q;
	logic [IW-1:0]    exact_idx_q;

	assign probe[0] = key;
	assign probe[1] = key & ~SPC_MASK;
	assign probe[2] = key & ~(SPC_MASK | GEN_MASK);
	assign probe[3] = key & EVT_MASK;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			hits[l] = rd_vld && (rd_data[KEY_W-1:0] == probe[l]);
		end
	end

	// lowest level wins
	always_comb begin
		new_hit = |hits;
		new_lvl = LVL_ALL;
		for (int l = 3; l >= 0; l--) begin
			if (hits[l]) begin
				new_lvl = 2'(l);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (clear) begin
			hit_q <= 1'b0;
		end else if (new_hit) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && new_hit && (!hit_q || new_lvl < lvl_q)) begin
			lvl_q <= new_lvl;
			hdl_q <= rd_data[ENT_W-1:KEY_W];
		end
		if (hits[0]) begin
			exact_idx_q <= rd_idx;
		end
	end

	assign res       = '{hit: hit_q, lvl: lvl_q, hdl: hdl_q};
	assign exact_idx = exact_idx_q;

endmodule

[tb/sv/tb_wildcard_fallback_handler_table.sv]
// Testbench for wildcard_fallback_handler_table: directed and random add, delete
// and lookup commands, each reply checked against a behavioral copy of the table.
// Depends on wfht_pkg and the wildcard_fallback_handler_table RTL.
module tb_wildcard_fallback_handler_table;
	import wfht_pkg::*;

	localparam int TABLE_ROWS = ENTRIES_DEF;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int PHASE_LEN = 120;
	localparam int RANDOM_CMDS = 1900;

	typedef struct {
		logic [1:0]       cmd;
		logic [FAM_W-1:0] fam;
		logic [GEN_W-1:0] gen;
		logic [SPC_W-1:0] spc;
		logic [EVT_W-1:0] evt;
		logic [HDL_W-1:0] hdl;
	} table_cmd_t;

	typedef struct {
		status_t          st;
		logic [HDL_W-1:0] hdl;
		logic [1:0]       lvl;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ENT_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	// behavioral copy of the table
	bit               row_used [TABLE_ROWS];
	logic [KEY_W-1:0] row_key [TABLE_ROWS];
	logic [HDL_W-1:0] row_hdl [TABLE_ROWS];

	table_cmd_t pending_cmds [$];
	table_reply_t predicted_replies [$];
	logic [15:0] key_pool [4][4];
	int n_accepted = 0;
	int n_replies = 0;
	int n_errors = 0;

	wildcard_fallback_handler_table #(.ENTRIES(TABLE_ROWS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] make_key(logic [FAM_W-1:0] fam,
			logic [GEN_W-1:0] gen, logic [SPC_W-1:0] spc, logic [EVT_W-1:0] evt);
		return {evt, spc, gen, fam};
	endfunction

	function automatic int find_row(logic [KEY_W-1:0] key);
		int hit;
		hit = -1;
		for (int i = 0; i < TABLE_ROWS; i++)
			if (hit < 0 && row_used[i] && row_key[i] == key)
				hit = i;
		return hit;
	endfunction

	// Apply one command to the table copy and return the reply it must give.
	function automatic table_reply_t apply_command(table_cmd_t c);
		table_reply_t r;
		logic [KEY_W-1:0] key;
		int s;
		r.st = ST_OK;
		r.hdl = '0;
		r.lvl = LVL_EXACT;
		key = make_key(c.fam, c.gen, c.spc, c.evt);
		case (c.cmd)
			CMD_ADD: begin
				s = find_row(key);
				for (int i = 0; i < TABLE_ROWS; i++)
					if (s < 0 && !row_used[i])
						s = i;
				if (s < 0) begin
					r.st = ST_FULL;
				end else begin
					row_used[s] = 1'b1;
					row_key[s] = key;
					row_hdl[s] = c.hdl;
				end
			end
			CMD_DEL: begin
				s = find_row(key);
				if (s >= 0)
					row_used[s] = 1'b0;
			end
			CMD_LOOKUP: begin
				r.st = ST_MISS;
				// probe exact, then widen the wildcard one field at a time
				for (int lv = 0; lv < 4; lv++) begin
					if (r.st == ST_MISS) begin
						s = find_row(make_key(lv >= 3 ? '0 : c.fam, lv >= 2 ? '0 : c.gen,
							lv >= 1 ? '0 : c.spc, c.evt));
						if (s >= 0) begin
							r.st = ST_OK;
							r.hdl = row_hdl[s];
							r.lvl = 2'(lv);
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic push_cmd(logic [1:0] cmd, logic [FAM_W-1:0] fam, logic [GEN_W-1:0] gen,
			logic [SPC_W-1:0] spc, logic [EVT_W-1:0] evt, logic [HDL_W-1:0] hdl);
		table_cmd_t c;
		c.cmd = cmd;
		c.fam = fam;
		c.gen = gen;
		c.spc = spc;
		c.evt = evt;
		c.hdl = hdl;
		pending_cmds.push_back(c);
	endtask

	// Mostly values from a small pool so that keys collide and wildcards hit.
	function automatic logic [15:0] draw(int field, int maxval);
		if ($urandom_range(99) < 15)
			return 16'($urandom_range(maxval));
		return key_pool[field][$urandom_range(3)] & 16'(maxval);
	endfunction

	function automatic int idle_phase();
		return (n_accepted / PHASE_LEN) % 4;
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got, want);
		$display("ERROR: reply %0d %s: got %0h, want %0h", n_replies, what, got, want);
		n_errors++;
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		table_cmd_t nxt;
		bit hold;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				predicted_replies.push_back(apply_command(pending_cmds.pop_front()));
				n_accepted <= n_accepted + 1;
			end
			hold = (idle_phase() == 1 && $urandom_range(99) < 49) ||
				(idle_phase() == 3 && $urandom_range(99) < 14);
			// the head of the queue stays there until its beat is taken
			if (pending_cmds.size() > 0 && !hold) begin
				nxt = pending_cmds[0];
				s_axis_tdata <= {nxt.hdl, nxt.evt, nxt.spc, nxt.gen, nxt.fam};
				s_axis_tuser <= nxt.cmd;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// reply monitor
	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_replies.size() == 0) begin
					report_mismatch("beat with no command outstanding", m_axis_tdata, '0);
				end else begin
					want = predicted_replies.pop_front();
					if (m_axis_tuser !== want.st)
						report_mismatch("status", m_axis_tuser, want.st);
					if (m_axis_tdata[15:0] !== want.hdl)
						report_mismatch("handler", m_axis_tdata[15:0], want.hdl);
					if (m_axis_tdata[17:16] !== want.lvl)
						report_mismatch("match level", m_axis_tdata[17:16], want.lvl);
					if (m_axis_tdata[23:18] !== 6'd0)
						report_mismatch("pad bits", m_axis_tdata[23:18], 6'd0);
				end
				n_replies++;
			end
			m_axis_tready <= !((idle_phase() == 2 && $urandom_range(99) < 49) ||
				(idle_phase() == 3 && $urandom_range(99) < 14));
		end
	end

	initial begin
		int r;
		logic [1:0] cmd;
		// pool: zero, all ones, two random values per field
		for (int f = 0; f < 4; f++) begin
			key_pool[f][0] = 16'h0000;
			key_pool[f][1] = 16'hFFFF;
			key_pool[f][2] = 16'($urandom);
			key_pool[f][3] = 16'($urandom);
		end

		push_cmd(CMD_LOOKUP, 8'd1, 8'd2, 16'd3, 16'd4, 16'h1234);	// empty table
		push_cmd(CMD_ADD, 8'd1, 8'd2, 16'd3, 16'd4, 16'hFFFF);
		push_cmd(CMD_LOOKUP, 8'd1, 8'd2, 16'd3, 16'd4, 16'h0);
		push_cmd(CMD_ADD, 8'd1, 8'd2, 16'd0, 16'd4, 16'h1111);
		push_cmd(CMD_LOOKUP, 8'd1, 8'd2, 16'd7, 16'd4, 16'h0);
		push_cmd(CMD_LOOKUP, 8'd1, 8'd2, 16'd0, 16'd4, 16'h0);	// wildcard equals exact
		push_cmd(CMD_ADD, 8'd1, 8'd0, 16'd0, 16'd4, 16'h2222);
		push_cmd(CMD_LOOKUP, 8'd1, 8'd9, 16'd9, 16'd4, 16'h0);
		push_cmd(CMD_ADD, 8'd0, 8'd0, 16'd0, 16'd4, 16'h0000);	// zero handle
		push_cmd(CMD_LOOKUP, 8'd5, 8'd5, 16'd5, 16'd4, 16'h0);
		push_cmd(CMD_LOOKUP, 8'd5, 8'd5, 16'd5, 16'd5, 16'h0);
		push_cmd(CMD_ADD, 8'd1, 8'd2, 16'd3, 16'd4, 16'h5A5A);	// overwrite
		push_cmd(CMD_LOOKUP, 8'd1, 8'd2, 16'd3, 16'd4, 16'h0);
		push_cmd(CMD_DEL, 8'd9, 8'd9, 16'd9, 16'd9, 16'h0);	// absent key
		push_cmd(CMD_DEL, 8'd1, 8'd2, 16'd3, 16'd4, 16'hFFFF);
		push_cmd(CMD_LOOKUP, 8'd1, 8'd2, 16'd3, 16'd4, 16'h0);
		push_cmd(CMD_NOP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_cmd(CMD_ADD, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_cmd(CMD_LOOKUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0);
		push_cmd(CMD_LOOKUP, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'hFFFF);
		push_cmd(CMD_ADD, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h8000);
		push_cmd(CMD_LOOKUP, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h0);

		// alternate fill, mixed and drain stretches so the table runs full and empty
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			r = $urandom_range(99);
			case ((i / 150) % 3)
				0: cmd = r < 60 ? CMD_ADD : r < 70 ? CMD_DEL : r < 98 ? CMD_LOOKUP : CMD_NOP;
				1: cmd = r < 25 ? CMD_ADD : r < 45 ? CMD_DEL : r < 98 ? CMD_LOOKUP : CMD_NOP;
				default: cmd = r < 15 ? CMD_ADD : r < 60 ? CMD_DEL : r < 98 ? CMD_LOOKUP : CMD_NOP;
			endcase
			push_cmd(cmd, 8'(draw(0, 255)), 8'(draw(1, 255)), draw(2, 65535), draw(3, 65535),
				16'($urandom));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() != 0 || predicted_replies.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (800000) @(posedge clk);
		$display("ERROR: timeout with %0d replies outstanding", predicted_replies.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
rtl/wfht_pkg.sv
rtl/wfht_ram.sv
rtl/wfht_probe.sv
rtl/wildcard_fallback_handler_table.sv
tb/sv/tb_wildcard_fallback_handler_table.sv
